// File: hdl/rmd_pkg.sv
// Package for the report message deframer: shared types, codes and helpers.
// No dependencies; imported by every module of the block.
package rmd_pkg;

  localparam int DEF_BUFFER_DEPTH = 256;
  localparam int Q_DEPTH          = 4;

  localparam logic [7:0] ETX_BYTE = 8'h03;
  localparam logic [7:0] GS_BYTE  = 8'h1D;

  localparam logic [7:0] RST_HEADER_FIRST  = 8'h81;
  localparam logic [7:0] RST_HEADER_SECOND = 8'h9F;
  localparam logic [7:0] RST_TYPED_MARKER  = 8'hF0;

  typedef enum logic [1:0] {
    CFG_HEADER_FIRST  = 2'd0,
    CFG_HEADER_SECOND = 2'd1,
    CFG_TYPED_MARKER  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    RK_READ    = 2'd0,
    RK_READY   = 2'd1,
    RK_DROPPED = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    POS_HDR0      = 2'd0,
    POS_HDR1      = 2'd1,
    POS_FIRST_PAY = 2'd2,
    POS_PAY       = 2'd3
  } pos_t;

  // Memory access issued by the front for one item
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  // Result descriptor leaving the front; read data joins it after the registered buffer read
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] length;
    logic       typed;
  } res_desc_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] length;
    logic       typed;
    logic [7:0] read_byte;
  } result_t;

  function automatic logic allowed_char(input logic [7:0] c);
    return (c >= 8'd32 && c <= 8'd126) || c == 8'd9 || c == 8'd10 ||
           c == 8'd13 || c == GS_BYTE || c == ETX_BYTE;
  endfunction

endpackage

// File: hdl/report_message_deframer_core.sv
// Report message deframer, top level.
//
// Input stream: one item per transfer. in_tuser is the opcode (0 = report
// byte, 1 = buffer read), in_tlast marks the last byte of a report. Report
// bytes are checked against the two header registers; payload is gathered
// into the message buffer until ETX, which returns a ready or dropped result.
// Reads return one buffer byte. Configuration writes go through cfg_we,
// cfg_addr and cfg_wdata and take effect at the next edge.
//
// Throughput: one item per cycle while in_tready is high. A result passes
// the registered buffer read and then the result queue before it shows on
// the output. The four-entry queue holds results while the receiver stalls;
// in_tready drops once the queue plus the item in the buffer stage would
// fill it, so nothing is lost.
//
// Reset (synchronous, rst_n low) clears the message and framing state and
// the queue, and restores the register defaults. The buffer is not cleared.
module report_message_deframer_core
  import rmd_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // data_byte[7:0], first_of_report[8], read_index[16:9]
  input  logic        in_tuser,   // opcode
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // message_length[7:0], typed_message[8], read_byte[16:9]
  output logic [1:0]  out_tuser,  // result_kind
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int QCW = $clog2(Q_DEPTH) + 1;

  mem_ctl_t       mem_ctl;
  logic [AW-1:0]  waddr, raddr;
  logic [7:0]     wdata;
  res_desc_t      desc;
  logic           push_valid;
  result_t        push_data;
  result_t        head_data;
  logic [QCW-1:0] q_count;
  logic [QCW-1:0] q_used;
  logic           in_xfer;

  assign q_used    = q_count + QCW'(push_valid);
  assign in_tready = q_used < QCW'(Q_DEPTH);
  assign in_xfer   = in_tvalid && in_tready;

  rmd_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .item_valid      (in_xfer),
    .opcode          (in_tuser),
    .data_byte       (in_tdata[7:0]),
    .first_of_report (in_tdata[8]),
    .last_of_report  (in_tlast),
    .read_index      (in_tdata[16:9]),
    .mem_ctl         (mem_ctl),
    .waddr           (waddr),
    .wdata           (wdata),
    .raddr           (raddr),
    .desc            (desc)
  );

  rmd_store #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .mem_ctl    (mem_ctl),
    .waddr      (waddr),
    .wdata      (wdata),
    .raddr      (raddr),
    .desc       (desc),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  rmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (out_tvalid && out_tready),
    .head_valid (out_tvalid),
    .head_data  (head_data),
    .count      (q_count)
  );

  assign out_tuser = head_data.kind;
  assign out_tdata = {7'd0, head_data.read_byte, head_data.typed, head_data.length};

endmodule

// File: hdl/rmd_front.sv
// Front part: configuration registers, report framing and message state.
// Issues buffer writes/reads and result descriptors. Depends on rmd_pkg.
module rmd_front
  import rmd_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
  localparam int AW = $clog2(BUFFER_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [7:0]    cfg_wdata,
  input  logic          item_valid,
  input  logic          opcode,
  input  logic [7:0]    data_byte,
  input  logic          first_of_report,
  input  logic          last_of_report,
  input  logic [7:0]    read_index,
  output mem_ctl_t      mem_ctl,
  output logic [AW-1:0] waddr,
  output logic [7:0]    wdata,
  output logic [AW-1:0] raddr,
  output res_desc_t     desc
);

  logic [7:0]    header_first_r, header_second_r, typed_marker_r;
  logic [AW-1:0] raw_r, raw_nxt;
  logic [AW-1:0] kept_r, kept_nxt;
  logic          ovf_r, ovf_nxt;
  logic          typed_r, typed_nxt;
  pos_t          pos_r, pos_nxt;
  logic          ign_r, ign_nxt;
  logic          start_zero_r, start_zero_nxt;
  logic          in_range;

  assign in_range = 32'(read_index) < 32'(BUFFER_DEPTH);
  assign raddr    = AW'(read_index);
  assign waddr    = kept_r;
  assign wdata    = data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_first_r  <= RST_HEADER_FIRST;
      header_second_r <= RST_HEADER_SECOND;
      typed_marker_r  <= RST_TYPED_MARKER;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_HEADER_FIRST:  header_first_r  <= cfg_wdata;
        CFG_HEADER_SECOND: header_second_r <= cfg_wdata;
        CFG_TYPED_MARKER:  typed_marker_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    raw_nxt        = raw_r;
    kept_nxt       = kept_r;
    ovf_nxt        = ovf_r;
    typed_nxt      = typed_r;
    pos_nxt        = pos_r;
    ign_nxt        = ign_r;
    start_zero_nxt = start_zero_r;
    mem_ctl        = '0;
    desc           = '0;
    if (item_valid) begin
      if (opcode == OP_READ) begin
        desc.valid = 1'b1;
        desc.kind  = RK_READ;
        mem_ctl.re = in_range;
      end else begin
        if (first_of_report) begin
          pos_nxt        = POS_HDR0;
          ign_nxt        = 1'b0;
          start_zero_nxt = (raw_r == '0);
        end
        if (!ign_nxt) begin
          case (pos_nxt)
            POS_HDR0: begin
              if (data_byte != header_first_r) ign_nxt = 1'b1;
              else pos_nxt = POS_HDR1;
            end
            POS_HDR1: begin
              if (data_byte != header_second_r) ign_nxt = 1'b1;
              else pos_nxt = POS_FIRST_PAY;
            end
            default: begin
              // typed check: first payload byte of a report opening a message
              if (pos_nxt == POS_FIRST_PAY && start_zero_nxt &&
                  data_byte == typed_marker_r)
                typed_nxt = 1'b1;
              pos_nxt = POS_PAY;
              if (data_byte == ETX_BYTE) begin
                desc.valid = 1'b1;
                if (ovf_r) begin
                  desc.kind = RK_DROPPED;
                end else begin
                  desc.kind   = RK_READY;
                  desc.length = 8'(kept_r);
                  desc.typed  = typed_nxt;
                end
                raw_nxt   = '0;
                kept_nxt  = '0;
                ovf_nxt   = 1'b0;
                typed_nxt = 1'b0;
                ign_nxt   = 1'b1;
              end else if (!ovf_r) begin
                if (raw_r != AW'(BUFFER_DEPTH - 1)) begin
                  raw_nxt = raw_r + AW'(1);
                  if (typed_nxt || allowed_char(data_byte)) begin
                    mem_ctl.we = 1'b1;
                    kept_nxt   = kept_r + AW'(1);
                  end
                end else begin
                  // overflow: drop the whole message until ETX
                  raw_nxt   = '0;
                  kept_nxt  = '0;
                  ovf_nxt   = 1'b1;
                  typed_nxt = 1'b0;
                end
              end
            end
          endcase
        end
        if (last_of_report) ign_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r        <= '0;
      kept_r       <= '0;
      ovf_r        <= 1'b0;
      typed_r      <= 1'b0;
      pos_r        <= POS_HDR0;
      ign_r        <= 1'b0;
      // the message count is zero at reset, so a report opened here starts clean
      start_zero_r <= 1'b1;
    end else begin
      raw_r        <= raw_nxt;
      kept_r       <= kept_nxt;
      ovf_r        <= ovf_nxt;
      typed_r      <= typed_nxt;
      pos_r        <= pos_nxt;
      ign_r        <= ign_nxt;
      start_zero_r <= start_zero_nxt;
    end
  end

endmodule

// File: hdl/rmd_store.sv
// Message buffer with registered read, plus the stage that joins read data
// to the result descriptor. Depends on rmd_pkg.
module rmd_store
  import rmd_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
  localparam int AW = $clog2(BUFFER_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mem_ctl_t      mem_ctl,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  input  res_desc_t     desc,
  output logic          push_valid,
  output result_t       push_data
);

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rd_data_r;
  logic       rd_en_r;
  logic       s1_valid_r;
  res_desc_t  s1_desc_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.we) mem[waddr] <= wdata;
    if (mem_ctl.re) rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= desc.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_desc_r <= desc;
    rd_en_r   <= mem_ctl.re;
  end

  assign push_valid          = s1_valid_r;
  assign push_data.kind      = s1_desc_r.kind;
  assign push_data.length    = s1_desc_r.length;
  assign push_data.typed     = s1_desc_r.typed;
  // out-of-range reads return zero
  assign push_data.read_byte = rd_en_r ? rd_data_r : 8'd0;

endmodule

// File: hdl/rmd_queue.sv
// Short result queue between the buffer stage and the output channel.
// The head entry drives the output directly. Depends on rmd_pkg.
module rmd_queue
  import rmd_pkg::*;
#(
  localparam int QA  = $clog2(Q_DEPTH),
  localparam int QCW = QA + 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  result_t        push_data,
  input  logic           pop,
  output logic           head_valid,
  output result_t        head_data,
  output logic [QCW-1:0] count
);

  result_t        entries [Q_DEPTH];
  logic [QA-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push_valid && !pop) count_nxt = count_r + QCW'(1);
    else if (!push_valid && pop) count_nxt = count_r - QCW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) wr_ptr_r <= wr_ptr_r + QA'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + QA'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) entries[wr_ptr_r] <= push_data;
  end

  assign head_valid = (count_r != '0);
  assign head_data  = entries[rd_ptr_r];
  assign count      = count_r;

endmodule

// File: hdl/rmd_checker.sv
// Port-level checks for the report message deframer output channel.
// Depends on rmd_pkg; bound to report_message_deframer_core below.
module rmd_checker
  import rmd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // no result survives reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("stalled result withdrawn");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_read_only_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != RK_READ |-> out_tdata[16:9] == 8'd0)
    else $error("read byte set on a message result");

  a_msg_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != RK_READY |-> out_tdata[8:0] == 9'd0)
    else $error("length or typed flag set on a non-ready result");

endmodule

bind report_message_deframer_core rmd_checker u_rmd_checker (.*);
